// ----- hw/rtl/ipf_pkg.sv -----
// shared types, constants and coefficient rom for the 2x interpolator
`default_nettype none
package ipf_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int ROM_SIZE            = 48;
    localparam int COEFF_COUNT_DEF     = 48;
    localparam int CHANNEL_COUNT_DEF   = 2;
    localparam int COEFF_FRAC_BITS_DEF = 18;
    localparam int MID_DEPTH           = 2;
    localparam int OUT_DEPTH           = 8;
    localparam int GROUP_SIZE          = 8;

    // coefficients in units of 1e-6
    localparam int COEFF_MICRO [ROM_SIZE] = '{
        -12, 0, 45, 0, -127, 0, 298, 0, -608, 0, 1118, 0,
        -1907, 0, 3075, 0, -4752, 0, 7110, 0, -10404, 0, 15063, 0,
        -21863, 0, 32561, 0, -51949, 0, 98609, 0, -315924, 500000, 315924, 0,
        -98609, 0, 51949, 0, -32561, 0, 21863, 0, -15063, 0, 10404, 0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       channel_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       channel_out;
        logic                       odd_phase;
    } t_out;

    // quantized coefficient, ties away from zero; zero past the rom or the coefficient count
    function automatic longint coeff_fixed(int k, int count, int frac);
        longint m;
        longint mag;
        longint q;
        if (k >= count || k >= ROM_SIZE) begin
            return 0;
        end
        m   = longint'(COEFF_MICRO[k]);
        mag = (m < 0) ? -m : m;
        q   = ((mag << frac) + 500000) / 1000000;
        return (m < 0) ? -q : q;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ipf_fifo.sv -----
// small register queue with count, used between the stages and at the output
`default_nettype none
module ipf_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_wdata,
    output logic                                o_full,
    input  wire logic                           i_pop,
    output logic [WIDTH-1:0]                    o_rdata,
    output logic                                o_empty,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (wr) begin
            n_wptr = (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CNTW'(wr) - CNTW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ipf_front.sv -----
// front: accepts items, shifts the channel's delay line and queues a tap snapshot
`default_nettype none
module ipf_front #(
    parameter int CHANNEL_COUNT = ipf_pkg::CHANNEL_COUNT_DEF,
    parameter int TAP_COUNT     = (ipf_pkg::COEFF_COUNT_DEF + 1) / 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    input  wire ipf_pkg::t_in                          i_data,
    input  wire logic                                  i_q_full,
    output logic                                       o_q_push,
    output logic [TAP_COUNT*ipf_pkg::SAMPLE_W:0]       o_q_data
);
    localparam int SW   = ipf_pkg::SAMPLE_W;
    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic signed [SW-1:0] r_dline [CHANNEL_COUNT][TAP_COUNT];
    logic                 accept;
    logic [CH_W-1:0]      ch_sel;
    logic [CH_W:0]        ch_wide;
    logic [TAP_COUNT*SW-1:0] taps;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    // out-of-range channel saturates to the last one
    always_comb begin
        ch_wide = (CH_W+1)'(i_data.channel_in);
        if (ch_wide >= (CH_W+1)'(CHANNEL_COUNT)) begin
            ch_sel = CH_W'(CHANNEL_COUNT - 1);
        end else begin
            ch_sel = ch_wide[CH_W-1:0];
        end
    end

    always_comb begin
        for (int t = 0; t < TAP_COUNT; t++) begin
            if (t == 0) begin
                taps[t*SW +: SW] = i_data.sample_in;
            end else begin
                taps[t*SW +: SW] = r_dline[ch_sel][t-1];
            end
        end
        o_q_data = {ch_sel[0], taps};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                for (int t = 0; t < TAP_COUNT; t++) begin
                    r_dline[c][t] <= '0;
                end
            end
        end else begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                if (accept && (ch_sel == CH_W'(c))) begin
                    for (int t = 0; t < TAP_COUNT; t++) begin
                        r_dline[c][t] <= taps[t*SW +: SW];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ipf_back.sv -----
// back: even then odd phase per item through multiplier lanes, adder tree and rounding
`default_nettype none
module ipf_back #(
    parameter int COEFF_COUNT     = ipf_pkg::COEFF_COUNT_DEF,
    parameter int COEFF_FRAC_BITS = ipf_pkg::COEFF_FRAC_BITS_DEF,
    parameter int TAP_COUNT       = (ipf_pkg::COEFF_COUNT_DEF + 1) / 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [TAP_COUNT*ipf_pkg::SAMPLE_W:0]  i_q_data,
    input  wire logic                                  i_q_empty,
    output logic                                       o_q_pop,
    input  wire logic [$clog2(ipf_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                       o_out_push,
    output ipf_pkg::t_out                              o_out_data
);
    localparam int SW    = ipf_pkg::SAMPLE_W;
    localparam int F     = COEFF_FRAC_BITS;
    localparam int CW    = F + 1;
    localparam int P     = SW + CW;
    localparam int SUM_W = P + $clog2(TAP_COUNT) + 1;
    localparam int GRP   = ipf_pkg::GROUP_SIZE;
    localparam int NGRP  = (TAP_COUNT + GRP - 1) / GRP;
    localparam int RW    = SUM_W - F + 2;
    localparam int OCW   = $clog2(ipf_pkg::OUT_DEPTH + 1);

    localparam logic signed [SUM_W:0] HALF = (SUM_W+1)'(1) << (F - 2);
    localparam logic signed [RW-1:0]  MAXV = RW'(32767);
    localparam logic signed [RW-1:0]  MINV = -RW'(32768);

    logic                  r_phase;
    logic                  issue;
    logic [OCW:0]          in_use;

    logic                  r_s1_v, r_s1_ch, r_s1_ph;
    logic signed [P-1:0]   r_s1_prod [TAP_COUNT];
    logic signed [P-1:0]   n_s1_prod [TAP_COUNT];
    logic                  r_s2_v, r_s2_ch, r_s2_ph;
    logic signed [SUM_W-1:0] r_s2_grp [NGRP];
    logic signed [SUM_W-1:0] n_s2_grp [NGRP];
    logic                  r_s3_v, r_s3_ch, r_s3_ph;
    logic signed [SUM_W-1:0] r_s3_acc, n_s3_acc;

    logic signed [SUM_W:0] biased;
    logic signed [RW-1:0]  shifted;
    logic signed [SW-1:0]  sat;

    // keep room in the output queue for every result still in the pipe
    assign in_use  = (OCW+1)'(i_out_count) + (OCW+1)'(r_s1_v) + (OCW+1)'(r_s2_v)
                   + (OCW+1)'(r_s3_v);
    assign issue   = !i_q_empty && (in_use < (OCW+1)'(ipf_pkg::OUT_DEPTH));
    assign o_q_pop = issue && r_phase;

    for (genvar t = 0; t < TAP_COUNT; t++) begin : g_lane
        localparam logic signed [CW-1:0] CE =
            CW'(ipf_pkg::coeff_fixed(2*t, COEFF_COUNT, F));
        localparam logic signed [CW-1:0] CO =
            CW'(ipf_pkg::coeff_fixed(2*t+1, COEFF_COUNT, F));
        logic signed [CW-1:0] coef;
        logic signed [SW-1:0] tap;
        assign coef         = r_phase ? CO : CE;
        assign tap          = $signed(i_q_data[t*SW +: SW]);
        assign n_s1_prod[t] = P'(tap) * P'(coef);
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_s2_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g*GRP + j < TAP_COUNT) begin
                    n_s2_grp[g] = n_s2_grp[g] + SUM_W'(r_s1_prod[g*GRP + j]);
                end
            end
        end
        n_s3_acc = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_s3_acc = n_s3_acc + r_s2_grp[g];
        end
    end

    // round half up after dropping F-1 bits (gain of two), then saturate
    always_comb begin
        biased  = (SUM_W+1)'(r_s3_acc) + HALF;
        shifted = $signed(biased[SUM_W:F-1]);
        if (shifted > MAXV) begin
            sat = 16'sh7fff;
        end else if (shifted < MINV) begin
            sat = 16'sh8000;
        end else begin
            sat = shifted[SW-1:0];
        end
    end

    assign o_out_push             = r_s3_v;
    assign o_out_data.sample_out  = sat;
    assign o_out_data.channel_out = r_s3_ch;
    assign o_out_data.odd_phase   = r_s3_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
        end else begin
            if (issue) begin
                r_phase <= !r_phase;
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ch   <= i_q_data[TAP_COUNT*SW];
        r_s1_ph   <= r_phase;
        r_s1_prod <= n_s1_prod;
        r_s2_ch   <= r_s1_ch;
        r_s2_ph   <= r_s1_ph;
        r_s2_grp  <= n_s2_grp;
        r_s3_ch   <= r_s2_ch;
        r_s3_ph   <= r_s2_ph;
        r_s3_acc  <= n_s3_acc;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/polyphase_2x_interpolator_unit.sv -----
// top level of the two-times polyphase interpolator
`default_nettype none
// Each accepted item (a Q1.15 sample and a channel) is shifted into that channel's
// delay line and produces two results, the even phase first and then the odd phase,
// each rounded half up and saturated to 16 bits. A channel number past the last
// channel is taken as the last channel. A new item is taken by the back end only
// once both phases of the last are done: its bank of multiplier lanes is shared by
// the two phases of an item, one phase per cycle while items wait and the output
// queue has room. A two-item queue between the front end and the back end and an
// eight-result output queue let input and output stall independently.
module polyphase_2x_interpolator_unit #(
    parameter int COEFF_COUNT     = ipf_pkg::COEFF_COUNT_DEF,
    parameter int CHANNEL_COUNT   = ipf_pkg::CHANNEL_COUNT_DEF,
    parameter int COEFF_FRAC_BITS = ipf_pkg::COEFF_FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ipf_pkg::t_in  i_data,
    output logic               empty,
    input  wire logic          pop,
    output ipf_pkg::t_out      o_data
);
    localparam int TAP_COUNT = (COEFF_COUNT + 1) / 2;
    localparam int QW        = TAP_COUNT * ipf_pkg::SAMPLE_W + 1;
    localparam int OW        = $bits(ipf_pkg::t_out);

    logic                                      q_push, q_full, q_pop, q_empty;
    logic [QW-1:0]                             q_wdata, q_rdata;
    logic [$clog2(ipf_pkg::MID_DEPTH+1)-1:0]   q_count;
    logic                                      out_push;
    ipf_pkg::t_out                             out_wdata;
    logic [OW-1:0]                             out_rdata;
    logic [$clog2(ipf_pkg::OUT_DEPTH+1)-1:0]   out_count;
    logic                                      out_full;

    assign full   = q_full;
    assign o_data = ipf_pkg::t_out'(out_rdata);

    ipf_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .TAP_COUNT     (TAP_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    ipf_fifo #(
        .WIDTH (QW),
        .DEPTH (ipf_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ipf_back #(
        .COEFF_COUNT     (COEFF_COUNT),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .TAP_COUNT       (TAP_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    ipf_fifo #(
        .WIDTH (OW),
        .DEPTH (ipf_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (OW'(out_wdata)),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/ipf_chk.sv -----
// port-level checks for the interpolator and the bind that attaches them
`default_nettype none
module ipf_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          push,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire ipf_pkg::t_out o_data
);
    // items accepted whose odd-phase result has not yet been taken
    logic [4:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 5'(push && !full) - 5'(pop && !empty && o_data.odd_phase);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("waiting result changed or vanished");

    a_even_then_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_data.odd_phase) |=>
            (empty || (o_data.odd_phase && o_data.channel_out == $past(o_data.channel_out))))
        else $error("even phase not followed by odd phase of the same channel");

    a_odd_then_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_data.odd_phase) |=> (empty || !o_data.odd_phase))
        else $error("odd phase not followed by an even phase");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pend != 5'd0))
        else $error("result shown with no item pending");

endmodule

bind polyphase_2x_interpolator_unit ipf_chk u_chk (.*);
`default_nettype wire
